[hdl/stt_pkg.sv]
package stt_pkg;

    // Position counter width; the result fields carry the low 16 bits
    localparam int POS_W       = 16;
    localparam int KW_MAX_LEN  = 10;
    localparam int KW_COUNT    = 31;
    localparam int LEN_W       = 4;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_CNT_W  = 3;

    // Token kinds
    localparam logic [5:0] K_IDENT    = 6'd31;
    localparam logic [5:0] K_INT      = 6'd32;
    localparam logic [5:0] K_FLOAT    = 6'd33;
    localparam logic [5:0] K_STRING   = 6'd34;
    localparam logic [5:0] K_PLUS     = 6'd35;
    localparam logic [5:0] K_MINUS    = 6'd36;
    localparam logic [5:0] K_ARROW    = 6'd37;
    localparam logic [5:0] K_STAR     = 6'd38;
    localparam logic [5:0] K_SLASH    = 6'd39;
    localparam logic [5:0] K_PERCENT  = 6'd40;
    localparam logic [5:0] K_ASSIGN   = 6'd41;
    localparam logic [5:0] K_EQ       = 6'd42;
    localparam logic [5:0] K_NE       = 6'd43;
    localparam logic [5:0] K_LT       = 6'd44;
    localparam logic [5:0] K_LE       = 6'd45;
    localparam logic [5:0] K_GT       = 6'd46;
    localparam logic [5:0] K_GE       = 6'd47;
    localparam logic [5:0] K_LPAREN   = 6'd48;
    localparam logic [5:0] K_RPAREN   = 6'd49;
    localparam logic [5:0] K_LBRACE   = 6'd50;
    localparam logic [5:0] K_RBRACE   = 6'd51;
    localparam logic [5:0] K_LBRACKET = 6'd52;
    localparam logic [5:0] K_RBRACKET = 6'd53;
    localparam logic [5:0] K_SEMI     = 6'd54;
    localparam logic [5:0] K_COLON    = 6'd55;
    localparam logic [5:0] K_COMMA    = 6'd56;
    localparam logic [5:0] K_DOT      = 6'd57;
    localparam logic [5:0] K_UNKNOWN  = 6'd58;
    localparam logic [5:0] K_END      = 6'd59;
    localparam logic [5:0] K_LEXEME   = 6'd60;
    localparam logic [5:0] K_ERROR    = 6'd61;

    // Keyword spellings, right-justified, first character highest
    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
        "dir", "dima", "idha", {"idha", "_mknch"}, {"ab9a", "_dor"}, "dor", "bdl", "khyr",
        "jarb", {"ila", "_ghalt"}, "dalla", "raja3", "jibli", "sa7", "ghalt", "walo",
        "tabi3i", "3ouchri", "5iyar", "fargh", "7arf", "nass", "jadwal", "9aleb",
        "anwa3", "ymkn", "ektb", "a9ra", "w", "wla", "machi"
    };

    localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd4, 4'd4, 4'd10, 4'd8, 4'd3, 4'd3, 4'd4,
        4'd4, 4'd9, 4'd5, 4'd5, 4'd5, 4'd3, 4'd5, 4'd4,
        4'd6, 4'd7, 4'd5, 4'd5, 4'd4, 4'd4, 4'd6, 4'd5,
        4'd5, 4'd4, 4'd4, 4'd4, 4'd1, 4'd3, 4'd5
    };

    // Scanner modes
    typedef enum logic [8:0] {
        M_IDLE         = 9'b000000001,
        M_IDENT        = 9'b000000010,
        M_FIRST_DIGIT  = 9'b000000100,
        M_NUMBER       = 9'b000001000,
        M_STRING       = 9'b000010000,
        M_OP           = 9'b000100000,
        M_LINE_COMMENT = 9'b001000000,
        M_BLOCK        = 9'b010000000,
        M_BLOCK_STAR   = 9'b100000000
    } mode_t;

    // One result item
    typedef struct packed {
        logic [5:0]  kind;
        logic [7:0]  char_val;
        logic [15:0] line_no;
        logic [15:0] column_no;
        logic        last;
    } result_t;

endpackage

[hdl/stt_kw_match.sv]
module stt_kw_match (
    input  logic [7:0]               word_buf [stt_pkg::KW_MAX_LEN],
    input  logic [stt_pkg::LEN_W-1:0] word_len,
    output logic [5:0]               word_kind
);
    import stt_pkg::*;

    logic [KW_COUNT-1:0] hit;

    // Parallel compare of the buffered word against every keyword
    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            hit[k] = (word_len == KW_LEN[k]);
            for (int i = 0; i < KW_MAX_LEN; i++) begin
                if (i < int'(KW_LEN[k])) begin
                    if (word_buf[i] != KW_TEXT[k][(int'(KW_LEN[k]) - 1 - i) * 8 +: 8]) begin
                        hit[k] = 1'b0;
                    end
                end
            end
        end
    end

    // Lowest matching keyword wins, identifier otherwise
    always_comb begin
        word_kind = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (hit[k]) begin
                word_kind = 6'(k);
            end
        end
    end

endmodule

[hdl/stt_out_fifo.sv]
module stt_out_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       wr_count,
    input  stt_pkg::result_t wr_data0,
    input  stt_pkg::result_t wr_data1,
    output logic             has_room,
    output logic             rd_valid,
    input  logic             rd_ready,
    output stt_pkg::result_t rd_data
);
    import stt_pkg::*;

    result_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  pop;

    // Room for two results keeps every input item acceptable in one go
    assign has_room = (cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(wr_count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        cnt_next    = cnt_reg + FIFO_CNT_W'(wr_count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (wr_count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= wr_data0;
        end
        if (wr_count == 2'd2) begin
            mem_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= wr_data1;
        end
    end

endmodule

[hdl/source_text_tokenizer.sv]
// Results are written into the registered result queue when their input item is accepted.
// Throughput: one input item per cycle while the result queue has room for two results; an item
// that causes two results hands them out one after the other through the single result port.
// A four-entry result queue decouples the sides; input waits when fewer than two slots are free.
// Reset (aresetn low, synchronous) empties the queue and returns the scanner to
// idle at line 1, column 1; end of source also returns the scanner there after its results.
module source_text_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic [0:0]  s_tuser,   // [0] kind (1 = end of source)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] lexeme_char, [23:8] line_no, [39:24] column_no
    output logic [5:0]  m_tuser,   // [5:0] token_kind
    output logic        m_tlast    // last result of the input item
);
    import stt_pkg::*;

    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

    // Scanner state
    mode_t            mode_reg, mode_next;
    logic [7:0]       pend_reg, pend_next;
    logic [7:0]       buf_reg [KW_MAX_LEN];
    logic [LEN_W-1:0] len_reg, len_next;
    logic             dot_reg, dot_next;
    logic             esc_reg, esc_next;
    logic [POS_W-1:0] line_reg, line_next;
    logic [POS_W-1:0] col_reg, col_next;

    logic             buf_we;
    logic [LEN_W-1:0] buf_idx;
    logic [7:0]       buf_data;

    logic             accept;
    logic [7:0]       c;
    logic             is_end;
    logic             c_digit, c_alpha, c_word;
    logic [POS_W-1:0] line_adv, col_adv;
    logic [5:0]       word_kind;

    // First result (closing emit, old position) and second (new position, old at end of source)
    logic             a_v, b_v;
    logic [5:0]       a_kind, b_kind;
    logic [7:0]       a_char, b_char;
    logic             b_old_pos;
    logic             fresh;
    logic [5:0]       two_kind;
    logic [5:0]       single_kind;
    logic             single_v;

    result_t          res_a, res_b, wr0, wr1;
    logic [1:0]       wr_count;
    logic             room;
    result_t          rd_data;

    assign accept  = s_tvalid && s_tready;
    assign s_tready = room;
    assign c       = s_tdata;
    assign is_end  = s_tuser[0];
    assign c_digit = (c >= "0") && (c <= "9");
    assign c_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    assign c_word  = c_digit || c_alpha || (c == "_");

    stt_kw_match u_kw (
        .word_buf  (buf_reg),
        .word_len  (len_reg),
        .word_kind (word_kind)
    );

    // Position after this byte, saturating
    always_comb begin
        if (c == 8'h0A) begin
            line_adv = (line_reg < POS_MAX) ? line_reg + POS_ONE : line_reg;
            col_adv  = POS_ONE;
        end else begin
            line_adv = line_reg;
            col_adv  = (col_reg < POS_MAX) ? col_reg + POS_ONE : col_reg;
        end
    end

    // Two-character operators and pending single operators
    always_comb begin
        two_kind = '0;
        if (pend_reg == "-" && c == ">") two_kind = K_ARROW;
        else if (pend_reg == "=" && c == "=") two_kind = K_EQ;
        else if (pend_reg == "!" && c == "=") two_kind = K_NE;
        else if (pend_reg == "<" && c == "=") two_kind = K_LE;
        else if (pend_reg == ">" && c == "=") two_kind = K_GE;

        single_v    = 1'b1;
        single_kind = K_MINUS;
        unique case (pend_reg)
            "-":     single_kind = K_MINUS;
            "=":     single_kind = K_ASSIGN;
            "<":     single_kind = K_LT;
            ">":     single_kind = K_GT;
            "/":     single_kind = K_SLASH;
            default: single_v = 1'b0;   // lone bang
        endcase
    end

    // Scanner next state and results
    always_comb begin
        mode_next = mode_reg;
        pend_next = pend_reg;
        len_next  = len_reg;
        dot_next  = dot_reg;
        esc_next  = esc_reg;
        line_next = line_reg;
        col_next  = col_reg;
        buf_we    = 1'b0;
        buf_idx   = len_reg;
        buf_data  = c;
        a_v       = 1'b0;
        a_kind    = K_IDENT;
        a_char    = '0;
        b_v       = 1'b0;
        b_kind    = K_LEXEME;
        b_char    = '0;
        b_old_pos = 1'b0;
        fresh     = 1'b0;

        if (is_end) begin
            // Close any open token, then end or error
            unique case (mode_reg)
                M_IDENT: begin
                    a_v    = 1'b1;
                    a_kind = word_kind;
                end
                M_FIRST_DIGIT, M_NUMBER: begin
                    a_v    = 1'b1;
                    a_kind = dot_reg ? K_FLOAT : K_INT;
                end
                M_OP: begin
                    a_v    = single_v;
                    a_kind = single_kind;
                end
                default: ;
            endcase
            b_v       = 1'b1;
            b_kind    = (mode_reg == M_STRING) ? K_ERROR : K_END;
            b_old_pos = 1'b1;
            mode_next = M_IDLE;
            pend_next = '0;
            len_next  = '0;
            dot_next  = 1'b0;
            esc_next  = 1'b0;
            line_next = POS_ONE;
            col_next  = POS_ONE;
        end else begin
            line_next = line_adv;
            col_next  = col_adv;
            unique case (mode_reg)
                M_IDENT: begin
                    if (c_word) begin
                        b_v    = 1'b1;
                        b_char = c;
                    end else begin
                        a_v    = 1'b1;
                        a_kind = word_kind;
                        fresh  = 1'b1;
                    end
                end
                M_FIRST_DIGIT, M_NUMBER: begin
                    if (mode_reg == M_FIRST_DIGIT && c_alpha) begin
                        b_v       = 1'b1;
                        b_char    = c;
                        mode_next = M_IDENT;
                    end else if (c_digit || c == ".") begin
                        if (c == ".") dot_next = 1'b1;
                        b_v       = 1'b1;
                        b_char    = c;
                        mode_next = M_NUMBER;
                    end else begin
                        a_v    = 1'b1;
                        a_kind = dot_reg ? K_FLOAT : K_INT;
                        fresh  = 1'b1;
                    end
                end
                M_STRING: begin
                    if (esc_reg) begin
                        esc_next = 1'b0;
                        b_v      = 1'b1;
                        b_char   = (c == "n") ? 8'h0A : ((c == "t") ? 8'h09 : c);
                    end else if (c == "\\") begin
                        esc_next = 1'b1;
                    end else if (c == "\"") begin
                        b_v       = 1'b1;
                        b_kind    = K_STRING;
                        mode_next = M_IDLE;
                    end else begin
                        b_v    = 1'b1;
                        b_char = c;
                    end
                end
                M_OP: begin
                    if (two_kind != '0) begin
                        b_v       = 1'b1;
                        b_kind    = two_kind;
                        mode_next = M_IDLE;
                    end else if (pend_reg == "/" && c == "/") begin
                        mode_next = M_LINE_COMMENT;
                    end else if (pend_reg == "/" && c == "*") begin
                        mode_next = M_BLOCK;
                    end else begin
                        a_v    = single_v;
                        a_kind = single_kind;
                        fresh  = 1'b1;
                    end
                end
                M_LINE_COMMENT: begin
                    if (c == 8'h0A) mode_next = M_IDLE;
                end
                M_BLOCK: begin
                    if (c == "*") mode_next = M_BLOCK_STAR;
                end
                M_BLOCK_STAR: begin
                    if (c == "/") mode_next = M_IDLE;
                    else if (c != "*") mode_next = M_BLOCK;
                end
                M_IDLE: fresh = 1'b1;
                default: fresh = 1'b1;
            endcase

            // Word bytes go to the keyword buffer; past the limit the length sticks
            if (!fresh && (mode_reg == M_IDENT || mode_next == M_IDENT) && b_v) begin
                if (len_reg < LEN_W'(KW_MAX_LEN)) begin
                    buf_we   = 1'b1;
                    len_next = len_reg + LEN_W'(1);
                end else begin
                    len_next = LEN_W'(KW_MAX_LEN + 1);
                end
            end

            // Start of a new token
            if (fresh) begin
                mode_next = M_IDLE;
                if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
                    mode_next = M_IDLE;
                end else if (c == "\"") begin
                    esc_next  = 1'b0;
                    mode_next = M_STRING;
                end else if (c_word) begin
                    buf_we    = 1'b1;
                    buf_idx   = '0;
                    len_next  = LEN_W'(1);
                    dot_next  = 1'b0;
                    b_v       = 1'b1;
                    b_char    = c;
                    mode_next = c_digit ? M_FIRST_DIGIT : M_IDENT;
                end else begin
                    b_v = 1'b1;
                    priority case (c)
                        "-", "=", "!", "<", ">", "/": begin
                            b_v       = 1'b0;
                            pend_next = c;
                            mode_next = M_OP;
                        end
                        "+": b_kind = K_PLUS;
                        "*": b_kind = K_STAR;
                        "%": b_kind = K_PERCENT;
                        "(": b_kind = K_LPAREN;
                        ")": b_kind = K_RPAREN;
                        "{": b_kind = K_LBRACE;
                        "}": b_kind = K_RBRACE;
                        "[": b_kind = K_LBRACKET;
                        "]": b_kind = K_RBRACKET;
                        ";": b_kind = K_SEMI;
                        ":": b_kind = K_COLON;
                        ",": b_kind = K_COMMA;
                        ".": b_kind = K_DOT;
                        default: begin
                            b_kind = K_UNKNOWN;
                            b_char = c;
                        end
                    endcase
                end
            end
        end
    end

    // Result packing
    always_comb begin
        res_a.kind      = a_kind;
        res_a.char_val  = a_char;
        res_a.line_no   = 16'(line_reg);
        res_a.column_no = 16'(col_reg);
        res_a.last      = !b_v;

        res_b.kind      = b_kind;
        res_b.char_val  = b_char;
        res_b.line_no   = b_old_pos ? 16'(line_reg) : 16'(line_next);
        res_b.column_no = b_old_pos ? 16'(col_reg) : 16'(col_next);
        res_b.last      = 1'b1;

        wr0      = a_v ? res_a : res_b;
        wr1      = res_b;
        wr_count = accept ? (2'(a_v) + 2'(b_v)) : 2'd0;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            pend_reg <= '0;
            len_reg  <= '0;
            dot_reg  <= 1'b0;
            esc_reg  <= 1'b0;
            line_reg <= POS_ONE;
            col_reg  <= POS_ONE;
        end else if (accept) begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
            len_reg  <= len_next;
            dot_reg  <= dot_next;
            esc_reg  <= esc_next;
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

    // Keyword buffer
    always_ff @(posedge aclk) begin
        if (accept && buf_we) begin
            buf_reg[buf_idx] <= buf_data;
        end
    end

    stt_out_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_count (wr_count),
        .wr_data0 (wr0),
        .wr_data1 (wr1),
        .has_room (room),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (rd_data)
    );

    assign m_tuser = rd_data.kind;
    assign m_tdata = {rd_data.column_no, rd_data.line_no, rd_data.char_val};
    assign m_tlast = rd_data.last;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

import stt_pkg::*;

// Token predictor plus the queue of result items still owed by the block
class token_scoreboard;
    string       kw_names [31] = '{
        "dir", "dima", "idha", string'({"idha", "_mknch"}), string'({"ab9a", "_dor"}),
        "dor", "bdl", "khyr",
        "jarb", string'({"ila", "_ghalt"}), "dalla", "raja3", "jibli", "sa7", "ghalt", "walo",
        "tabi3i", "3ouchri", "5iyar", "fargh", "7arf", "nass", "jadwal", "9aleb",
        "anwa3", "ymkn", "ektb", "a9ra", "w", "wla", "machi"
    };
    mode_t       mode;
    byte unsigned op_ch;
    string       word;
    bit          word_long;
    bit          saw_dot;
    bit          in_esc;
    int unsigned line;
    int unsigned col;
    result_t     owed [$];
    result_t     step_out [$];
    int          errors;

    function new();
        errors = 0;
        clear();
    endfunction

    function void clear();
        mode = M_IDLE;
        op_ch = 0;
        word = "";
        word_long = 0;
        saw_dot = 0;
        in_esc = 0;
        line = 1;
        col = 1;
    endfunction

    function bit is_digit(byte unsigned c);
        return c >= "0" && c <= "9";
    endfunction

    function bit is_alpha(byte unsigned c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function void put(logic [5:0] k, byte unsigned ch);
        result_t r;
        if (step_out.size() < 2) begin
            r.kind = k;
            r.char_val = ch;
            r.line_no = line[15:0];
            r.column_no = col[15:0];
            r.last = 0;
            step_out = {step_out, r};
        end
    endfunction

    // line/column after a consumed byte, saturating
    function void advance(byte unsigned c);
        if (c == 8'h0a) begin
            if (line < 65535) line++;
            col = 1;
        end else if (col < 65535) begin
            col++;
        end
    endfunction

    function void push_char(byte unsigned c);
        if (word.len() < KW_MAX_LEN) word = {word, string'(c)};
        else word_long = 1;
    endfunction

    function void end_word();
        logic [5:0] k;
        k = K_IDENT;
        if (!word_long) begin
            foreach (kw_names[i]) begin
                if (kw_names[i] == word) begin
                    k = 6'(i);
                    break;
                end
            end
        end
        put(k, 0);
    endfunction

    // pending single-char operator; lone bang gives nothing
    function void single_op(byte unsigned p);
        case (p)
            "-": put(K_MINUS, 0);
            "=": put(K_ASSIGN, 0);
            "<": put(K_LT, 0);
            ">": put(K_GT, 0);
            "/": put(K_SLASH, 0);
            default: ;
        endcase
    endfunction

    function void start_token(byte unsigned c);
        mode = M_IDLE;
        if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) return;
        if (c == "\"") begin
            in_esc = 0;
            mode = M_STRING;
            return;
        end
        if (is_digit(c) || is_alpha(c) || c == "_") begin
            word = "";
            word_long = 0;
            saw_dot = 0;
            push_char(c);
            put(K_LEXEME, c);
            mode = is_digit(c) ? M_FIRST_DIGIT : M_IDENT;
            return;
        end
        case (c)
            "-", "=", "!", "<", ">", "/": begin
                op_ch = c;
                mode = M_OP;
            end
            "+": put(K_PLUS, 0);
            "*": put(K_STAR, 0);
            "%": put(K_PERCENT, 0);
            "(": put(K_LPAREN, 0);
            ")": put(K_RPAREN, 0);
            "{": put(K_LBRACE, 0);
            "}": put(K_RBRACE, 0);
            "[": put(K_LBRACKET, 0);
            "]": put(K_RBRACKET, 0);
            ";": put(K_SEMI, 0);
            ":": put(K_COLON, 0);
            ",": put(K_COMMA, 0);
            ".": put(K_DOT, 0);
            default: put(K_UNKNOWN, c);
        endcase
    endfunction

    // accepted input item: predict its results
    function void note_input(bit eos, byte unsigned c);
        bit fresh;
        logic [5:0] two;
        fresh = 0;
        step_out.delete();
        if (eos) begin
            case (mode)
                M_IDENT: end_word();
                M_FIRST_DIGIT, M_NUMBER: put(saw_dot ? K_FLOAT : K_INT, 0);
                M_OP: single_op(op_ch);
                default: ;
            endcase
            if (mode == M_STRING) put(K_ERROR, 0);
            else put(K_END, 0);
            clear();
        end else begin
            case (mode)
                M_IDENT: begin
                    if (is_alpha(c) || is_digit(c) || c == "_") begin
                        advance(c);
                        push_char(c);
                        put(K_LEXEME, c);
                    end else begin
                        end_word();
                        fresh = 1;
                    end
                end
                M_FIRST_DIGIT, M_NUMBER: begin
                    if (mode == M_FIRST_DIGIT && is_alpha(c)) begin
                        advance(c);
                        push_char(c);
                        put(K_LEXEME, c);
                        mode = M_IDENT;
                    end else if (is_digit(c) || c == ".") begin
                        advance(c);
                        if (c == ".") saw_dot = 1;
                        put(K_LEXEME, c);
                        mode = M_NUMBER;
                    end else begin
                        put(saw_dot ? K_FLOAT : K_INT, 0);
                        fresh = 1;
                    end
                end
                M_STRING: begin
                    advance(c);
                    if (in_esc) begin
                        in_esc = 0;
                        put(K_LEXEME, c == "n" ? 8'h0a : (c == "t" ? 8'h09 : c));
                    end else if (c == "\\") begin
                        in_esc = 1;
                    end else if (c == "\"") begin
                        put(K_STRING, 0);
                        mode = M_IDLE;
                    end else begin
                        put(K_LEXEME, c);
                    end
                end
                M_OP: begin
                    two = 0;
                    if (op_ch == "-" && c == ">") two = K_ARROW;
                    else if (op_ch == "=" && c == "=") two = K_EQ;
                    else if (op_ch == "!" && c == "=") two = K_NE;
                    else if (op_ch == "<" && c == "=") two = K_LE;
                    else if (op_ch == ">" && c == "=") two = K_GE;
                    if (two != 0) begin
                        advance(c);
                        put(two, 0);
                        mode = M_IDLE;
                    end else if (op_ch == "/" && c == "/") begin
                        advance(c);
                        mode = M_LINE_COMMENT;
                    end else if (op_ch == "/" && c == "*") begin
                        advance(c);
                        mode = M_BLOCK;
                    end else begin
                        single_op(op_ch);
                        fresh = 1;
                    end
                end
                M_LINE_COMMENT: begin
                    advance(c);
                    if (c == 8'h0a) mode = M_IDLE;
                end
                M_BLOCK: begin
                    advance(c);
                    if (c == "*") mode = M_BLOCK_STAR;
                end
                M_BLOCK_STAR: begin
                    advance(c);
                    if (c == "/") mode = M_IDLE;
                    else if (c != "*") mode = M_BLOCK;
                end
                default: fresh = 1;
            endcase
            if (fresh) begin
                advance(c);
                start_token(c);
            end
        end
        if (step_out.size() > 0) step_out[step_out.size()-1].last = 1;
        owed = {owed, step_out};
    endfunction

    // accepted result item against the oldest owed one
    function void check_result(result_t got);
        result_t exp;
        if (owed.size() == 0) begin
            $display("%0t: unexpected result kind=%0d char=%02h line=%0d col=%0d last=%0b",
                     $time, got.kind, got.char_val, got.line_no, got.column_no, got.last);
            errors++;
            return;
        end
        exp = owed.pop_front();
        if (got.kind !== exp.kind) begin
            $display("%0t: token_kind exp %0d got %0d", $time, exp.kind, got.kind);
            errors++;
        end
        if (got.char_val !== exp.char_val) begin
            $display("%0t: lexeme_char exp %02h got %02h", $time, exp.char_val, got.char_val);
            errors++;
        end
        if (got.line_no !== exp.line_no) begin
            $display("%0t: line_no exp %0d got %0d", $time, exp.line_no, got.line_no);
            errors++;
        end
        if (got.column_no !== exp.column_no) begin
            $display("%0t: column_no exp %0d got %0d", $time, exp.column_no, got.column_no);
            errors++;
        end
        if (got.last !== exp.last) begin
            $display("%0t: last exp %0b got %0b", $time, exp.last, got.last);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic [0:0]  s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic [5:0]  m_tuser;
    logic        m_tlast;

    token_scoreboard tokens = new();
    bit   idle_on = 1;
    int   ready_hold = 0;
    int   sent = 0;
    bit   src_eos [$];
    byte unsigned src_char [$];

    source_text_tokenizer dut (.*);

    always #5 aclk = ~aclk;

    // result side: random stall bursts while idle_on is set, always ready otherwise
    always @(posedge aclk) begin
        if (!idle_on) begin
            m_tready <= 1;
        end else if (ready_hold > 0) begin
            ready_hold--;
            m_tready <= 0;
        end else if ($urandom_range(0, 5) == 0) begin
            ready_hold = $urandom_range(0, 14);
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        result_t r;
        if (aresetn && m_tvalid && m_tready) begin
            r.kind = m_tuser;
            r.char_val = m_tdata[7:0];
            r.line_no = m_tdata[23:8];
            r.column_no = m_tdata[39:24];
            r.last = m_tlast;
            tokens.check_result(r);
        end
    end

    function void add_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            src_eos = {src_eos, 1'b0};
            src_char = {src_char, 8'(s[i])};
        end
    endfunction

    function void add_byte(int unsigned c);
        src_eos = {src_eos, 1'b0};
        src_char = {src_char, 8'(c)};
    endfunction

    function void add_eos();
        src_eos = {src_eos, 1'b1};
        src_char = {src_char, 8'($urandom_range(0, 255))};
    endfunction

    // one random token with random content
    function void add_token();
        int n;
        case ($urandom_range(0, 13))
            0: add_text(tokens.kw_names[$urandom_range(0, 30)]);
            1, 2: begin
                n = $urandom_range(1, 14);
                add_byte($urandom_range(0, 1) ? "_" : "a" + $urandom_range(0, 25));
                for (int i = 1; i < n; i++) begin
                    case ($urandom_range(0, 3))
                        0: add_byte("0" + $urandom_range(0, 9));
                        1: add_byte("A" + $urandom_range(0, 25));
                        2: add_byte("_");
                        default: add_byte("a" + $urandom_range(0, 25));
                    endcase
                end
            end
            3: begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    add_byte($urandom_range(0, 4) == 0 ? "." : "0" + $urandom_range(0, 9));
            end
            4: begin
                add_byte("0" + $urandom_range(0, 9));
                add_byte("a" + $urandom_range(0, 25));
            end
            5: begin
                add_byte("\"");
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        add_byte("\\");
                        add_byte($urandom_range(0, 2) == 0 ? "n" : $urandom_range(0, 255));
                    end else begin
                        add_byte($urandom_range(0, 255));
                    end
                end
                add_byte("\"");
            end
            6, 7: begin
                n = $urandom_range(0, 22);
                case (n)
                    0: add_text("+");  1: add_text("-");  2: add_text("->");
                    3: add_text("*");  4: add_text("/");  5: add_text("%");
                    6: add_text("=");  7: add_text("=="); 8: add_text("!=");
                    9: add_text("<");  10: add_text("<="); 11: add_text(">");
                    12: add_text(">="); 13: add_text("("); 14: add_text(")");
                    15: add_text("{"); 16: add_text("}"); 17: add_text("[");
                    18: add_text("]"); 19: add_text(";"); 20: add_text(":");
                    21: add_text(","); default: add_text("!");
                endcase
            end
            8: begin
                add_text("//");
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++) add_byte($urandom_range(0, 255));
                add_byte(8'h0a);
            end
            9: begin
                add_text("/*");
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++)
                    add_byte($urandom_range(0, 1) ? "*" : $urandom_range(0, 255));
                add_text("*/");
            end
            10: add_byte($urandom_range(0, 255));
            11: add_byte($urandom_range(128, 255));
            default: add_byte($urandom_range(0, 1) ? " " : 8'h0a);
        endcase
        // mostly separated, sometimes run together
        if ($urandom_range(0, 2) != 0) add_byte($urandom_range(0, 3) == 0 ? 8'h0a : " ");
    endfunction

    task automatic send_all();
        while (src_eos.size() > 0) begin
            if (idle_on && $urandom_range(0, 4) == 0) begin
                s_tvalid <= 0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            s_tvalid <= 1;
            s_tuser <= src_eos[0];
            s_tdata <= src_char[0];
            do @(posedge aclk); while (!s_tready);
            tokens.note_input(src_eos[0], src_char[0]);
            sent++;
            void'(src_eos.pop_front());
            void'(src_char.pop_front());
        end
    endtask

    initial begin
        int waited;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: keywords, long word, digit-letter, numbers, operators, strings
        add_text("dir idha");
        add_text("_mknch 3ouchri machi w abcdefghijk 9x 7 12.5 3. ! != -> ");
        add_text("== <= >= < > = - / + * % ( ) { } [ ] ; : , . ");
        add_text("\"a\\nb\\t\\q\\\\\" // note\n/* x **/ ");
        add_byte(8'h80);
        add_byte(8'h00);
        add_byte(8'hff);
        add_text("x1");
        add_eos();
        add_text("\"ab\\");
        add_eos();
        add_text("\"ab");
        add_eos();
        add_text("/* open");
        add_eos();
        add_text("-");
        add_eos();
        add_text("12.");
        add_eos();
        add_eos();
        send_all();

        // random sources
        while (sent < 750) begin
            if (sent > 600) idle_on = 0;
            else if ($urandom_range(0, 3) == 0) idle_on = !idle_on;
            for (int i = $urandom_range(3, 20); i > 0; i--) add_token();
            if ($urandom_range(0, 5) == 0) begin
                add_byte("\"");
                if ($urandom_range(0, 1)) add_byte("\\");
            end
            add_eos();
            send_all();
        end
        idle_on = 0;
        s_tvalid <= 0;

        waited = 0;
        while (tokens.owed.size() > 0 && waited < 10000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);
        if (tokens.errors == 0 && tokens.owed.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("tb_top: done, errors");
        $finish;
    end
endmodule

[filelist.f]
hdl/stt_pkg.sv
hdl/stt_kw_match.sv
hdl/stt_out_fifo.sv
hdl/source_text_tokenizer.sv
tb/sv/tb_top.sv
